@@ rtl/core/tbcp_pkg.sv @@
// Shared types and constants for the threshold / brightness / contrast pixel block.
// Used by every module under rtl/core except tbcp_fifo; depends on nothing.
`default_nettype none

package tbcp_pkg;

  // Field and register widths
  localparam int unsigned PixW  = 8;
  localparam int unsigned CfgW  = 9;
  localparam int unsigned IdxW  = 2;

  // Gain is unsigned Q9.16, up to 2^24 for the steepest stretch
  localparam int unsigned GainW = 25;
  localparam int unsigned ProdW = PixW + GainW;
  localparam int unsigned FracW = 16;

  // Combined additive term and the pre-clamp value
  localparam int unsigned BiasW = 17;
  localparam int unsigned ValW  = 18;

  // Setup divider: one quotient bit per step
  localparam int unsigned DivSteps = GainW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned DenW     = 9;
  localparam int unsigned DiffW    = 35;

  // Queue depths
  localparam int unsigned MidDepthDef = 4;
  localparam int unsigned OutDepthDef = 2;

  // Register indexes
  localparam logic [IdxW-1:0] RegThreshold  = 2'd0;
  localparam logic [IdxW-1:0] RegBrightness = 2'd1;
  localparam logic [IdxW-1:0] RegContrast   = 2'd2;

  // Reset mapping is the identity
  localparam logic [GainW-1:0] GainUnity = 25'd65536;

  // Front-end gating from the setup unit
  typedef struct packed {
    logic [CfgW-1:0] threshold;
    logic            busy;
  } tbcp_gate_t;

  // Mapping parameters for the back end
  typedef struct packed {
    logic [GainW-1:0]        gain;
    logic signed [BiasW-1:0] bias;
    logic [PixW-1:0]         lo;
    logic [PixW-1:0]         hi;
  } tbcp_map_t;

endpackage

`default_nettype wire

@@ rtl/core/tbcp_fifo.sv @@
// Small register queue with first-word output, used between front and back and at the output.
// Depends on nothing; Depth must be at least 2.
`default_nettype none

module tbcp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tbcp_setup.sv @@
// Configuration registers and the setup unit that derives gain, clamp bounds and bias.
// Depends on tbcp_pkg; the gain division runs one quotient bit per cycle.
`default_nettype none

module tbcp_setup (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tbcp_pkg::IdxW-1:0]   cfg_index_i,
  input  wire logic [tbcp_pkg::CfgW-1:0]   cfg_data_i,
  output tbcp_pkg::tbcp_gate_t             gate_o,
  output tbcp_pkg::tbcp_map_t              map_o
);

  import tbcp_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StDiff = 3'd3;
  localparam logic [2:0] StOffx = 3'd4;
  localparam logic [2:0] StBias = 3'd5;

  logic [2:0]              state_q, state_d;
  logic [CfgW-1:0]         thr_q, thr_d;
  logic [CfgW-1:0]         bright_q, bright_d;
  logic [CfgW-1:0]         contr_q, contr_d;
  logic [GainW-1:0]        num_q, num_d;
  logic [PixW-1:0]         rem_q, rem_d;
  logic [DenW-1:0]         den_q, den_d;
  logic [DivCntW-1:0]      cnt_q, cnt_d;
  logic [GainW-1:0]        gain_q, gain_d;
  logic signed [DiffW-1:0] diff_q, diff_d;
  logic signed [BiasW-1:0] offx_q, offx_d;
  logic signed [BiasW-1:0] bias_q, bias_d;
  logic [PixW-1:0]         lo_q, lo_d;
  logic [PixW-1:0]         hi_q, hi_d;

  logic                    wr, restart;
  logic [CfgW-1:0]         contr_sat;
  logic [PixW-1:0]         neg_span;
  logic [DenW-1:0]         pos_den;
  logic [CfgW:0]           lo_twice;
  logic [DenW-1:0]         trial;
  logic                    qbit;
  logic [DiffW-1:0]        gain_x255;
  logic [DiffW-1:0]        diff_mag;
  logic [DiffW-FracW-3:0]  offx_mag;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;
  assign restart     = wr && (cfg_index_i == RegBrightness || cfg_index_i == RegContrast);

  // Saturate the most negative contrast code
  assign contr_sat = (cfg_data_i == {1'b1, {(CfgW-1){1'b0}}}) ?
                     {1'b1, {(CfgW-2){1'b0}}, 1'b1} : cfg_data_i;

  // Negative contrast: 255 + c; positive: 256 - c
  assign neg_span = PixW'(CfgW'(255) + contr_q);
  assign pos_den  = DenW'(10'd256 - {contr_q[CfgW-1], contr_q});
  assign lo_twice = (CfgW+1)'(1) - {contr_q[CfgW-1], contr_q};

  // One restoring division step
  assign trial = {rem_q, num_q[GainW-1]};
  assign qbit  = (trial >= den_q);

  // 255 * g as a shift and subtract
  assign gain_x255 = {{(DiffW-GainW-8){1'b0}}, gain_q, 8'd0} -
                     {{(DiffW-GainW){1'b0}}, gain_q};

  // Centering offset truncates toward zero
  assign diff_mag = diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
  assign offx_mag = diff_mag[DiffW-2:FracW+1];

  always_comb begin
    state_d  = state_q;
    thr_d    = thr_q;
    bright_d = bright_q;
    contr_d  = contr_q;
    num_d    = num_q;
    rem_d    = rem_q;
    den_d    = den_q;
    cnt_d    = cnt_q;
    gain_d   = gain_q;
    diff_d   = diff_q;
    offx_d   = offx_q;
    bias_d   = bias_q;
    lo_d     = lo_q;
    hi_d     = hi_q;

    // Take register writes
    if (wr) begin
      case (cfg_index_i)
        RegThreshold:  thr_d    = cfg_data_i;
        RegBrightness: bright_d = cfg_data_i;
        RegContrast:   contr_d  = contr_sat;
        default: ;
      endcase
    end

    case (state_q)
      StIdle: ;
      StLoad: begin
        // Set up dividend, divisor and clamp bounds
        rem_d = '0;
        cnt_d = '0;
        if (contr_q[CfgW-1]) begin
          num_d = {1'b0, neg_span, 16'h007F};
          den_d = DenW'(255);
          lo_d  = lo_twice[PixW:1];
          hi_d  = PixW'(255) - lo_twice[PixW:1];
        end else begin
          num_d = {1'b1, 16'd0, pos_den[DenW-1:1]};
          den_d = pos_den;
          lo_d  = '0;
          hi_d  = PixW'(255);
        end
        state_d = StDiv;
      end
      StDiv: begin
        // Shift in one quotient bit
        rem_d = qbit ? PixW'(trial - den_q) : trial[PixW-1:0];
        num_d = {num_q[GainW-2:0], qbit};
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StDiff;
        end
      end
      StDiff: begin
        gain_d = num_q;
        state_d = StOffx;
      end
      StOffx: begin
        // 2^24 - 255*g, only for stretching contrast
        if (contr_q[CfgW-1]) begin
          diff_d = '0;
        end else begin
          diff_d = $signed(DiffW'(1 << 24) - gain_x255);
        end
        state_d = StBias;
      end
      StBias: begin
        offx_d  = diff_q[DiffW-1] ? -$signed(BiasW'(offx_mag)) : $signed(BiasW'(offx_mag));
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase

    // Fold brightness, low bound and centering offset into one term
    if (state_q == StIdle && offx_q != bias_q) begin
      bias_d = bias_q;
    end
    if (state_q == StBias) begin
      bias_d = $signed({{(BiasW-CfgW){bright_q[CfgW-1]}}, bright_q}) +
               $signed({{(BiasW-PixW){1'b0}}, lo_q}) +
               (diff_q[DiffW-1] ? -$signed(BiasW'(offx_mag)) : $signed(BiasW'(offx_mag)));
    end

    // Restart setup on any write that moves the mapping
    if (restart) begin
      state_d = StLoad;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      thr_q    <= '0;
      bright_q <= '0;
      contr_q  <= '0;
      gain_q   <= GainUnity;
      offx_q   <= '0;
      bias_q   <= '0;
      lo_q     <= '0;
      hi_q     <= PixW'(255);
    end else begin
      state_q  <= state_d;
      thr_q    <= thr_d;
      bright_q <= bright_d;
      contr_q  <= contr_d;
      gain_q   <= gain_d;
      offx_q   <= offx_d;
      bias_q   <= bias_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
    end
  end

  // Divider working registers
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    cnt_q  <= cnt_d;
    diff_q <= diff_d;
  end

  assign gate_o.threshold = thr_q;
  assign gate_o.busy      = (state_q != StIdle);
  assign map_o.gain       = gain_q;
  assign map_o.bias       = bias_q;
  assign map_o.lo         = lo_q;
  assign map_o.hi         = hi_q;

endmodule

`default_nettype wire

@@ rtl/core/tbcp_front.sv @@
// Front end: accepts pixels, applies the threshold and hands items to the middle queue.
// Depends on tbcp_pkg for the gate struct from the setup unit.
`default_nettype none

module tbcp_front (
  input  wire logic                       push_i,
  output logic                            full_o,
  input  wire logic [tbcp_pkg::PixW-1:0]  pixel_in_i,
  input  wire tbcp_pkg::tbcp_gate_t       gate_i,
  input  wire logic                       q_full_i,
  output logic                            q_push_o,
  output logic [tbcp_pkg::PixW-1:0]       q_data_o
);

  import tbcp_pkg::*;

  logic below;

  // Hold off input while the queue is full or setup is running
  assign full_o   = q_full_i || gate_i.busy;
  assign q_push_o = push_i && !full_o;

  // Drop pixels below the threshold to zero
  assign below    = ({1'b0, pixel_in_i} < gate_i.threshold);
  assign q_data_o = below ? '0 : pixel_in_i;

endmodule

`default_nettype wire

@@ rtl/core/tbcp_back.sv @@
// Back end: scales by the gain, rounds, adds the bias and clamps to the output range.
// Depends on tbcp_pkg; one multiply stage, then add and clamp into the output queue.
`default_nettype none

module tbcp_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       q_empty_i,
  input  wire logic [tbcp_pkg::PixW-1:0]  q_data_i,
  output logic                            q_pop_o,
  input  wire tbcp_pkg::tbcp_map_t        map_i,
  input  wire logic                       out_full_i,
  output logic                            out_push_o,
  output logic [tbcp_pkg::PixW-1:0]       out_data_o
);

  import tbcp_pkg::*;

  logic                    v1_q;
  logic [ProdW-1:0]        prod_q;
  logic                    advance;
  logic [ValW-1:0]         scaled;
  logic signed [ValW-1:0]  val;
  logic signed [ValW-1:0]  lo_ext, hi_ext;

  // Advance the multiply stage unless its item is blocked
  assign advance    = !v1_q || !out_full_i;
  assign q_pop_o    = advance && !q_empty_i;
  assign out_push_o = v1_q && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (advance) begin
      v1_q <= q_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      prod_q <= ProdW'(q_data_i) * ProdW'(map_i.gain);
    end
  end

  // Round half up and add the combined offset
  assign scaled = {{(ValW-(ProdW-FracW)){1'b0}}, prod_q[ProdW-1:FracW]} +
                  ValW'(prod_q[FracW-1]);
  assign val    = $signed(scaled) +
                  $signed({{(ValW-BiasW){map_i.bias[BiasW-1]}}, map_i.bias});
  assign lo_ext = $signed({{(ValW-PixW){1'b0}}, map_i.lo});
  assign hi_ext = $signed({{(ValW-PixW){1'b0}}, map_i.hi});

  // Clamp, low bound first
  always_comb begin
    if (val < lo_ext) begin
      out_data_o = map_i.lo;
    end else if (val > hi_ext) begin
      out_data_o = map_i.hi;
    end else begin
      out_data_o = val[PixW-1:0];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/threshold_brightness_contrast_pixel.sv @@
// Top level of the threshold / brightness / contrast pixel block.
// Depends on tbcp_pkg, tbcp_setup, tbcp_front, tbcp_fifo and tbcp_back.
`default_nettype none

// Takes one 8-bit pixel per cycle on a queue-style port while full is low and returns one
// adjusted pixel per input, in order. Sustained rate is one item per clock when nothing
// stalls; an item is registered in the middle queue, then the multiply stage, then the
// output queue, from which it shows on the result ports. A write to the brightness or
// contrast register starts the setup unit, whose gain divider produces one quotient bit per
// cycle; full stays high until that setup pass is done. Threshold writes take effect at
// once. After reset the mapping is the identity and no setup pass runs.
module threshold_brightness_contrast_pixel #(
  parameter int unsigned MidDepth = tbcp_pkg::MidDepthDef,
  parameter int unsigned OutDepth = tbcp_pkg::OutDepthDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [tbcp_pkg::IdxW-1:0]  cfg_index_i,
  input  wire logic [tbcp_pkg::CfgW-1:0]  cfg_data_i,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [tbcp_pkg::PixW-1:0]  pixel_in_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [tbcp_pkg::PixW-1:0]       pixel_out_o
);

  import tbcp_pkg::*;

  tbcp_gate_t      gate;
  tbcp_map_t       map;
  logic            mid_push, mid_full, mid_pop, mid_empty;
  logic [PixW-1:0] mid_wdata, mid_rdata;
  logic            out_push, out_full;
  logic [PixW-1:0] out_wdata;

  // Configuration and derived mapping
  tbcp_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gate_o      (gate),
    .map_o       (map)
  );

  // Accept and threshold
  tbcp_front u_front (
    .push_i     (push),
    .full_o     (full),
    .pixel_in_i (pixel_in_i),
    .gate_i     (gate),
    .q_full_i   (mid_full),
    .q_push_o   (mid_push),
    .q_data_o   (mid_wdata)
  );

  // Decouple front and back
  tbcp_fifo #(
    .Width (PixW),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_wdata),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_rdata),
    .empty_o (mid_empty)
  );

  // Scale, offset and clamp
  tbcp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (mid_empty),
    .q_data_i   (mid_rdata),
    .q_pop_o    (mid_pop),
    .map_i      (map),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_data_o (out_wdata)
  );

  // Hold results until taken
  tbcp_fifo #(
    .Width (PixW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (pixel_out_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

@@ rtl/core/tbcp_checker.sv @@
// Port-level checks for the threshold / brightness / contrast pixel block, bound to its top.
// Depends on tbcp_pkg for register indexes.
`default_nettype none

module tbcp_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       cfg_valid_i,
  input wire logic                       cfg_ready_o,
  input wire logic [tbcp_pkg::IdxW-1:0]  cfg_index_i,
  input wire logic                       full,
  input wire logic                       empty,
  input wire logic                       pop,
  input wire logic [tbcp_pkg::PixW-1:0]  pixel_out_o
);

  import tbcp_pkg::*;

  // Come out of reset with nothing queued and input open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> empty && !full)
    else $error("queue not idle after reset");

  // Stall input while setup recomputes the mapping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o &&
     (cfg_index_i == RegBrightness || cfg_index_i == RegContrast)) |=> full ##1 full)
    else $error("input open during setup");

  // Hold a waiting result until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty && $stable(pixel_out_o))
    else $error("waiting result changed");

endmodule

bind threshold_brightness_contrast_pixel tbcp_checker u_tbcp_checker (.*);

`default_nettype wire

@@ sim/threshold_brightness_contrast_pixel_tb.sv @@
// Testbench for threshold_brightness_contrast_pixel: random and directed pixels with a
// bit-accurate predictor checked against every popped result, in order.
// Depends on tbcp_pkg and the RTL under rtl/core.
`default_nettype none

module threshold_brightness_contrast_pixel_tb;

  localparam int CycleLimit   = 600000;
  localparam int PixelTarget  = 1750;
  localparam int LongHoldLen  = 250;
  localparam int SettleCycles = 8;

  // Index 3 is outside the register map and must be ignored
  localparam logic [tbcp_pkg::IdxW-1:0] RegSpare = 2'd3;

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [tbcp_pkg::IdxW-1:0]     cfg_index_i = '0;
  logic [tbcp_pkg::CfgW-1:0]     cfg_data_i  = '0;
  logic                          push        = 1'b0;
  logic                          full;
  logic [tbcp_pkg::PixW-1:0]     pixel_in_i  = '0;
  logic                          empty;
  logic                          pop         = 1'b0;
  logic [tbcp_pkg::PixW-1:0]     pixel_out_o;

  // Predictor copy of the registers
  logic [tbcp_pkg::CfgW-1:0] thr_q      = '0;
  logic [tbcp_pkg::CfgW-1:0] bright_q   = '0;
  logic [tbcp_pkg::CfgW-1:0] contrast_q = '0;

  logic [tbcp_pkg::PixW-1:0] pixel_queue[$];
  logic [tbcp_pkg::PixW-1:0] pixel_out_expected[$];

  int  fail_count     = 0;
  int  pixels_queued  = 0;
  int  accepted_count = 0;
  int  cycle_count    = 0;
  int  push_gap       = 0;
  int  pop_gap        = 0;
  int  hold_left      = 0;
  int  hold_mark      = 60;
  bit  idle_en        = 1'b0;
  bit  push_taken     = 1'b0;
  bit  pop_taken      = 1'b0;

  threshold_brightness_contrast_pixel dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .pixel_in_i  (pixel_in_i),
    .empty       (empty),
    .pop         (pop),
    .pixel_out_o (pixel_out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Threshold, then contrast gain and rounding, offsets, clamp
  function automatic logic [tbcp_pkg::PixW-1:0] adjust_pixel(
    input logic [tbcp_pkg::PixW-1:0] pix
  );
    longint p, c, b, g, lo, hi, offx, v, d;
    p = (pix < thr_q) ? 0 : longint'(pix);
    c = longint'($signed(contrast_q));
    b = longint'($signed(bright_q));
    lo = 0;
    hi = 255;
    offx = 0;
    if (c < -255) c = -255;
    if (c < 0) begin
      // compress: gain (255+c)/255, range narrows around the middle
      g  = ((255 + c) * 65536 + 127) / 255;
      lo = (1 - c) / 2;
      hi = 255 - lo;
    end else begin
      // stretch: gain 256/(256-c) with a centering offset, truncated toward zero
      d    = 256 - c;
      g    = ((longint'(1) << 24) + d / 2) / d;
      offx = (longint'(255) * 65536 - 255 * g + 65536) / 131072;
    end
    v = ((p * g + 32768) >>> 16) + b + lo + offx;
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    return v[tbcp_pkg::PixW-1:0];
  endfunction

  // Mostly short gaps, a few long ones, none while idling is off
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sample both handshakes and check results
  always @(posedge clk_i) begin
    push_taken <= rst_ni && push && !full;
    pop_taken  <= rst_ni && pop && !empty;
    if (rst_ni && push && !full) begin
      pixel_out_expected.push_back(adjust_pixel(pixel_in_i));
      accepted_count++;
    end
    if (rst_ni && pop && !empty) begin
      if (pixel_out_expected.size() == 0) begin
        $error("pixel_out: unexpected item, actual %0d", pixel_out_o);
        fail_count++;
      end else begin
        if (pixel_out_o !== pixel_out_expected[0]) begin
          $error("pixel_out mismatch: expected %0d, actual %0d",
                 pixel_out_expected[0], pixel_out_o);
          fail_count++;
        end
        void'(pixel_out_expected.pop_front());
      end
    end
  end

  // Input driver: hold the front item until taken, then idle a while
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push_taken) begin
        void'(pixel_queue.pop_front());
        push_gap = next_gap();
      end
      if (push_gap != 0) begin
        push_gap--;
        push <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        push       <= 1'b1;
        pixel_in_i <= pixel_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Output driver: random stalls plus long hold-offs to back the block up
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (pop_taken) pop_gap = next_gap();
      if (hold_left == 0 && accepted_count >= hold_mark) begin
        hold_left = LongHoldLen;
        hold_mark += 700;
      end
      if (hold_left != 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap != 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [tbcp_pkg::IdxW-1:0] idx,
                           input logic [tbcp_pkg::CfgW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tbcp_pkg::RegThreshold:  thr_q      = data;
      tbcp_pkg::RegBrightness: bright_q   = data;
      tbcp_pkg::RegContrast:   contrast_q = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for every pending item to be sent and checked, then let the pipe settle
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || pixel_out_expected.size() != 0 || push)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [tbcp_pkg::CfgW-1:0] pick_signed_reg();
    case ($urandom_range(0, 7))
      0:       return 9'h100;      // most negative code, saturates for contrast
      1:       return -9'sd255;
      2:       return 9'sd255;
      3:       return '0;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  function automatic logic [tbcp_pkg::PixW-1:0] pick_pixel();
    int t;
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: begin
        // land near the threshold edge
        t = int'(thr_q) + $urandom_range(0, 4) - 2;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t[tbcp_pkg::PixW-1:0];
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int n;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Identity mapping out of reset, field extremes and alternating bits
    pixel_queue = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd127, 8'd128, 8'h55, 8'hAA};
    wait_idle();

    // Threshold above the pixel range forces every pixel to zero
    write_reg(tbcp_pkg::RegThreshold, 9'd256);
    pixel_queue = '{8'd200, 8'd255};
    wait_idle();
    write_reg(tbcp_pkg::RegThreshold, 9'd511);
    pixel_queue = '{8'd255};
    wait_idle();

    // Full compression: every output collapses to the middle code 127
    write_reg(tbcp_pkg::RegThreshold, 9'd0);
    write_reg(tbcp_pkg::RegContrast, -9'sd255);
    pixel_queue = '{8'd0, 8'd127, 8'd255};
    wait_idle();

    // Most negative contrast code saturates
    write_reg(tbcp_pkg::RegContrast, 9'h100);
    pixel_queue = '{8'd0, 8'd255};
    wait_idle();

    // Steepest stretch with maximum brightness
    write_reg(tbcp_pkg::RegContrast, 9'sd255);
    write_reg(tbcp_pkg::RegBrightness, 9'sd255);
    pixel_queue = '{8'd0, 8'd128, 8'd255};
    wait_idle();

    // Most negative brightness
    write_reg(tbcp_pkg::RegContrast, '0);
    write_reg(tbcp_pkg::RegBrightness, 9'h100);
    pixel_queue = '{8'd255, 8'd100};
    wait_idle();

    // Write outside the map, then back to identity
    write_reg(RegSpare, 9'h1FF);
    write_reg(tbcp_pkg::RegBrightness, '0);
    pixel_queue = '{8'd0, 8'd200};
    wait_idle();

    // Random phases, each with a fresh register setting
    while (pixels_queued < PixelTarget) begin
      idle_en = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0:       write_reg(tbcp_pkg::RegThreshold, '0);
        1:       write_reg(tbcp_pkg::RegThreshold, 9'd256);
        2:       write_reg(tbcp_pkg::RegThreshold, 9'($urandom_range(257, 511)));
        default: write_reg(tbcp_pkg::RegThreshold, 9'($urandom_range(0, 200)));
      endcase
      write_reg(tbcp_pkg::RegBrightness, pick_signed_reg());
      write_reg(tbcp_pkg::RegContrast, pick_signed_reg());
      if ($urandom_range(0, 3) == 0) write_reg(RegSpare, 9'($urandom_range(0, 511)));
      n = $urandom_range(20, 80);
      repeat (n) pixel_queue.push_back(pick_pixel());
      pixels_queued += n;
      wait_idle();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (pixel_out_expected.size() != 0) begin
      $error("pixel_out: %0d expected items never arrived", pixel_out_expected.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
